@@ hw/rtl/smbs_pkg.sv @@
// Shared constants, types and address helper for the sorted-matrix binary search block.
// Depends on nothing; imported by the top level, the checker and the testbench top.
package smbs_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;

    localparam int DATA_W = 32;
    localparam int SIZE_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Counts reach the bound itself; search bounds also need a sign and a carry bit.
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int RLO_W = ROW_CNT_W + 2;
    localparam int CLO_W = COL_CNT_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = CFG_IDX_W'(1);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_COL  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Row-major placement of element (row, col).
    function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_AW-1:0] row,
                                                    logic [COL_AW-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

@@ hw/rtl/smbs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module smbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sorted_matrix_binary_search.sv @@
// Top level of the sorted-matrix binary search block: matrix RAM, search sequencer, output register.
// Depends on smbs_pkg and smbs_ram.

// A write transaction (cmd 0) stores one element. A search transaction
// (cmd 1) runs two binary searches, one probe per cycle through the single read port of the
// matrix RAM: first column 0 for the last row whose first element is at most the key, then
// that row for the key. The next transaction is taken when the search ends. The result sits
// in an output register, so a new transaction is accepted while an earlier result still
// waits. Zero rows or zero columns in use answers not found.
module sorted_matrix_binary_search
    import smbs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_cmd,
    input  logic [3:0]               i_row_index,
    input  logic [3:0]               i_col_index,
    input  logic signed [DATA_W-1:0] i_data_value,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_found,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [SIZE_W-1:0]        i_cfg_data
);

    localparam logic signed [RLO_W-1:0] R_ONE = RLO_W'(1);
    localparam logic signed [RLO_W-1:0] R_MINUS_ONE = '1;
    localparam logic signed [CLO_W-1:0] C_ONE = CLO_W'(1);
    localparam logic signed [CLO_W-1:0] C_ZERO = '0;

    function automatic logic signed [RLO_W-1:0] row_mid(logic signed [RLO_W-1:0] lo,
                                                        logic signed [RLO_W-1:0] hi);
        return (lo + hi + R_ONE) >>> 1;
    endfunction

    function automatic logic signed [CLO_W-1:0] col_mid(logic signed [CLO_W-1:0] lo,
                                                        logic signed [CLO_W-1:0] hi);
        return (lo + hi) >>> 1;
    endfunction

    t_state                    r_state, n_state;
    logic [SIZE_W-1:0]         r_rows_in_use, r_cols_in_use;
    logic signed [DATA_W-1:0]  r_key, n_key;
    logic signed [RLO_W-1:0]   r_rlo, n_rlo, r_rhi, n_rhi, r_rmid, n_rmid;
    logic signed [CLO_W-1:0]   r_clo, n_clo, r_chi, n_chi, r_cmid, n_cmid;
    logic [ROW_AW-1:0]         r_row, n_row;
    logic                      r_hit, n_hit;
    logic                      r_out_valid, n_out_valid;
    logic                      r_found, n_found;

    logic [ROW_CNT_W-1:0]      nr_sat;
    logic [COL_CNT_W-1:0]      nc_sat;
    logic                      in_fire;
    logic                      cell_le, cell_eq, cell_lt;
    logic signed [RLO_W-1:0]   rs_lo, rs_hi;
    logic signed [CLO_W-1:0]   cs_lo, cs_hi;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;

    smbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign in_fire     = i_in_valid && o_in_ready;

    // Sizes above the matrix bounds saturate.
    assign nr_sat = (32'(r_rows_in_use) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS)
                                                    : ROW_CNT_W'(r_rows_in_use);
    assign nc_sat = (32'(r_cols_in_use) > MAX_COLS) ? COL_CNT_W'(MAX_COLS)
                                                    : COL_CNT_W'(r_cols_in_use);

    // The read data always belongs to the probe issued in the previous cycle.
    assign cell_le = ($signed(ram_rdata) <= r_key);
    assign cell_eq = ($signed(ram_rdata) == r_key);
    assign cell_lt = ($signed(ram_rdata) < r_key);

    assign rs_lo = cell_le ? r_rmid : r_rlo;
    assign rs_hi = cell_le ? r_rhi : (r_rmid - R_ONE);
    assign cs_lo = cell_lt ? (r_cmid + C_ONE) : r_clo;
    assign cs_hi = cell_lt ? r_chi : (r_cmid - C_ONE);

    // Writes come only from a write transaction and probes only from a search, so the single RAM
    // never sees a probe read and a write of the same entry overlap.
    assign ram_waddr = cell_addr(ROW_AW'(i_row_index), COL_AW'(i_col_index));

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_rlo       = r_rlo;
        n_rhi       = r_rhi;
        n_rmid      = r_rmid;
        n_clo       = r_clo;
        n_chi       = r_chi;
        n_cmid      = r_cmid;
        n_row       = r_row;
        n_hit       = r_hit;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        ram_we      = 1'b0;
        ram_raddr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_cmd == CMD_WRITE)) begin
                    ram_we = (32'(i_row_index) < MAX_ROWS) && (32'(i_col_index) < MAX_COLS);
                end else if (in_fire && (i_cmd == CMD_SEARCH)) begin
                    n_key = i_data_value;
                    if (nr_sat == '0 || nc_sat == '0) begin
                        n_hit   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_rlo     = R_MINUS_ONE;
                        n_rhi     = RLO_W'(nr_sat) - R_ONE;
                        n_rmid    = row_mid(R_MINUS_ONE, RLO_W'(nr_sat) - R_ONE);
                        ram_raddr = cell_addr(ROW_AW'(n_rmid), '0);
                        n_state   = S_ROW;
                    end
                end
            end
            S_ROW: begin
                n_rlo = rs_lo;
                n_rhi = rs_hi;
                if (rs_lo < rs_hi) begin
                    n_rmid    = row_mid(rs_lo, rs_hi);
                    ram_raddr = cell_addr(ROW_AW'(n_rmid), '0);
                end else if (rs_lo < 0) begin
                    // Key lies below the first element of every row.
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_row     = ROW_AW'(rs_lo);
                    n_clo     = C_ZERO;
                    n_chi     = CLO_W'(nc_sat) - C_ONE;
                    n_cmid    = col_mid(C_ZERO, CLO_W'(nc_sat) - C_ONE);
                    ram_raddr = cell_addr(ROW_AW'(rs_lo), COL_AW'(n_cmid));
                    n_state   = S_COL;
                end
            end
            S_COL: begin
                n_clo = cs_lo;
                n_chi = cs_hi;
                if (cell_eq) begin
                    n_hit   = 1'b1;
                    n_state = S_DONE;
                end else if (cs_lo <= cs_hi) begin
                    n_cmid    = col_mid(cs_lo, cs_hi);
                    ram_raddr = cell_addr(r_row, COL_AW'(n_cmid));
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_rows_in_use <= SIZE_W'(1);
            r_cols_in_use <= SIZE_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_data;
                    CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_rlo   <= n_rlo;
        r_rhi   <= n_rhi;
        r_rmid  <= n_rmid;
        r_clo   <= n_clo;
        r_chi   <= n_chi;
        r_cmid  <= n_cmid;
        r_row   <= n_row;
        r_hit   <= n_hit;
        r_found <= n_found;
    end

`ifndef SYNTHESIS
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished search");

    a_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("matrix write during a search");

    a_row_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_rlo < r_rhi && r_rmid > r_rlo && r_rmid <= r_rhi))
        else $error("row probe outside its search range");

    a_col_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (r_clo <= r_chi && r_cmid >= r_clo && r_cmid <= r_chi))
        else $error("column probe outside its search range");
`endif

endmodule

@@ tb/sorted_matrix_binary_search_checker.sv @@
// Checker for the sorted-matrix binary search block: watches the input, result and
// size-register channels, keeps its own matrix and sizes, and compares every result in order.
// Depends on smbs_pkg.
module sorted_matrix_binary_search_checker
    import smbs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_cmd,
    input  logic [3:0]               i_row_index,
    input  logic [3:0]               i_col_index,
    input  logic signed [DATA_W-1:0] i_data_value,

    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_found,

    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [SIZE_W-1:0]        i_cfg_data,

    output int                       o_searches_open,
    output int                       o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] key;
        logic                     found;
    } t_search_answer;

    logic signed [DATA_W-1:0] matrix_copy [MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0]        rows_setting = SIZE_W'(1);
    logic [SIZE_W-1:0]        cols_setting = SIZE_W'(1);
    t_search_answer           answers_due [$];
    int                       mismatch_total = 0;

    // Finds the last row whose first word is at most the key, then looks for the key in it.
    function automatic logic key_present(logic signed [DATA_W-1:0] key);
        int nr;
        int nc;
        int lo;
        int hi;
        int mid;
        int row;
        logic signed [DATA_W-1:0] probe;
        nr = (rows_setting > MAX_ROWS) ? MAX_ROWS : int'(rows_setting);
        nc = (cols_setting > MAX_COLS) ? MAX_COLS : int'(cols_setting);
        if (nr == 0 || nc == 0)
            return 1'b0;
        lo = -1;
        hi = nr - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (matrix_copy[mid][0] <= key)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo < 0)
            return 1'b0;
        row = lo;
        lo = 0;
        hi = nc - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            probe = matrix_copy[row][mid];
            if (probe == key)
                return 1'b1;
            if (probe < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    function automatic void log_mismatch(string what);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("mismatch: %s", what);
    endfunction

    // Results are retired before new searches are queued, since a result leaving at this
    // edge always belongs to an earlier transaction.
    always @(posedge i_clk) begin : watch
        t_search_answer due;
        if (!i_rst_n) begin
            rows_setting = SIZE_W'(1);
            cols_setting = SIZE_W'(1);
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROWS_IN_USE: rows_setting = i_cfg_data;
                    CFG_COLS_IN_USE: cols_setting = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    log_mismatch($sformatf("found=%b with no search outstanding", i_found));
                end else begin
                    due = answers_due.pop_front();
                    if (i_found !== due.found)
                        log_mismatch($sformatf("key %0d: found expected %b, actual %b",
                                               due.key, due.found, i_found));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_WRITE) begin
                    matrix_copy[i_row_index][i_col_index] = i_data_value;
                end else begin
                    due.key = i_data_value;
                    due.found = key_present(i_data_value);
                    answers_due.push_back(due);
                end
            end
        end
        o_searches_open <= answers_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

@@ tb/sorted_matrix_binary_search_test.sv @@
// Testbench top for the sorted-matrix binary search block: clock, reset, matrix fills,
// searches, size changes and result back-pressure, with the verdict at the end.
// Depends on smbs_pkg, sorted_matrix_binary_search and sorted_matrix_binary_search_checker.
module sorted_matrix_binary_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smbs_pkg::*;

    localparam int ITEM_GOAL = 1400;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 800_000;
    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     cmd = CMD_WRITE;
    logic [3:0]               row_index = '0;
    logic [3:0]               col_index = '0;
    logic signed [DATA_W-1:0] data_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     found;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_ROWS_IN_USE;
    logic [SIZE_W-1:0]        cfg_data = '0;

    int   searches_open;
    int   mismatches;
    int   hold_off_asks = 0;
    bit   steady_sender = 1'b0;
    int   items_sent = 0;
    int   cycle_count = 0;
    int   rows_now = 1;
    int   cols_now = 1;

    // What the stimulus last wrote to each cell, used to aim search keys.
    logic signed [DATA_W-1:0] written_value [MAX_ROWS][MAX_COLS];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_matrix_binary_search u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_row_index  (row_index),
        .i_col_index  (col_index),
        .i_data_value (data_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_found      (found),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    sorted_matrix_binary_search_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_cmd           (cmd),
        .i_row_index     (row_index),
        .i_col_index     (col_index),
        .i_data_value    (data_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_found         (found),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_searches_open (searches_open),
        .o_mismatches    (mismatches)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_matrix_binary_search_test: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(int bound);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return SIZE_W'(bound);
        if (roll < 22)
            return SIZE_W'(1);
        if (roll < 27)
            return SIZE_W'(0);
        if (roll < 35)
            return SIZE_W'($urandom_range(bound + 1, (1 << SIZE_W) - 1));
        return SIZE_W'($urandom_range(1, bound));
    endfunction

    function automatic int in_use(logic [SIZE_W-1:0] setting, int bound);
        return (setting > bound) ? bound : int'(setting);
    endfunction

    // Mostly keys that sit in the matrix or right beside an entry, some extremes and noise.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int roll;
        int r;
        int c;
        logic signed [DATA_W-1:0] entry;
        roll = $urandom_range(0, 99);
        if (rows_now == 0 || cols_now == 0 || roll >= 85) begin
            case ($urandom_range(0, 4))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return '0;
                default: return $urandom;
            endcase
        end
        r = $urandom_range(0, rows_now - 1);
        c = $urandom_range(0, cols_now - 1);
        entry = written_value[r][c];
        if (roll < 50)
            return entry;
        if (roll < 70)
            return entry + 1;
        return entry - 1;
    endfunction

    // Valid is left high after acceptance; the next call either replaces the payload in the
    // same step or lowers valid for a gap.
    task automatic send_item(logic kind, logic [3:0] row, logic [3:0] col,
                             logic signed [DATA_W-1:0] value);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= kind;
        row_index <= row;
        col_index <= col;
        data_value <= value;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic write_cell(logic [3:0] row, logic [3:0] col,
                              logic signed [DATA_W-1:0] value);
        send_item(CMD_WRITE, row, col, value);
        written_value[row][col] = value;
    endtask

    task automatic look_up(logic signed [DATA_W-1:0] key);
        send_item(CMD_SEARCH, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), key);
    endtask

    // Writes only cause no result, so a fixed settle follows the last outstanding search.
    task automatic drain_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (searches_open != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sizes(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROWS_IN_USE;
        cfg_data <= rows;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_COLS_IN_USE;
        cfg_data <= cols;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rows_now = in_use(rows, MAX_ROWS);
        cols_now = in_use(cols, MAX_COLS);
    endtask

    // Fills the region in use, either strictly ascending in row-major order or scrambled.
    task automatic fill_region(bit ordered);
        longint level;
        int step_cap;
        logic signed [DATA_W-1:0] value;
        step_cap = ($urandom_range(0, 1) != 0) ? 3 : (1 << 20);
        level = longint'(WORD_MIN);
        if ($urandom_range(0, 9) != 0)
            level = level + longint'($urandom_range(0, 32'hEFFF_FFFF));
        for (int r = 0; r < rows_now; r++) begin
            for (int c = 0; c < cols_now; c++) begin
                if (ordered) begin
                    value = DATA_W'(level);
                    if (r == rows_now - 1 && c == cols_now - 1 && $urandom_range(0, 9) == 0)
                        value = WORD_MAX;
                    level = level + longint'($urandom_range(1, step_cap));
                end else if ($urandom_range(0, 1) != 0) begin
                    value = DATA_W'(int'($urandom_range(0, 20)) - 10);
                end else begin
                    value = $urandom;
                end
                write_cell(4'(r), 4'(c), value);
            end
        end
    endtask

    // A long hold starts whenever the stimulus has asked for one more than were served.
    initial begin : receiver
        int hold_left;
        int span_left;
        int stall;
        int holds_seen;
        bit taking;
        hold_left = 0;
        span_left = 0;
        holds_seen = 0;
        taking = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_off_asks != holds_seen) begin
                hold_left = LONG_HOLD_CYCLES;
                holds_seen = hold_off_asks;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (span_left == 0) begin
                    stall = taking ? pick_gap() : 0;
                    taking = (stall == 0);
                    if (taking)
                        span_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                                : $urandom_range(1, 12);
                    else
                        span_left = stall;
                end
                span_left--;
                out_ready <= taking;
            end
            @(posedge clk);
        end
    end

    initial begin : stimulus
        int phase;
        int searches;
        logic [SIZE_W-1:0] rows_pick;
        logic [SIZE_W-1:0] cols_pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // One-by-one matrix out of reset: extreme words as entry and key.
        write_cell(4'd0, 4'd0, WORD_MIN);
        look_up(WORD_MIN);
        look_up(WORD_MAX);
        look_up('0);
        write_cell(4'd0, 4'd0, WORD_MAX);
        look_up(WORD_MAX);
        look_up(WORD_MIN);
        look_up(WORD_MAX - 1);
        write_cell(4'd15, 4'd15, -1);
        write_cell(4'd15, 4'd0, WORD_MIN);
        write_cell(4'd0, 4'd15, WORD_MAX);
        write_cell(4'd0, 4'd0, '0);
        look_up('0);
        look_up(-1);
        look_up(1);

        // With zero rows or zero columns in use nothing can be found.
        drain_block();
        set_sizes(SIZE_W'(0), SIZE_W'(MAX_COLS));
        look_up('0);
        look_up(WORD_MIN);
        drain_block();
        set_sizes(SIZE_W'(MAX_ROWS), SIZE_W'(0));
        look_up('0);
        look_up(WORD_MAX);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            drain_block();
            if (phase == 0) begin
                rows_pick = '1;
                cols_pick = SIZE_W'(MAX_COLS);
            end else begin
                rows_pick = pick_size(MAX_ROWS);
                cols_pick = pick_size(MAX_COLS);
            end
            set_sizes(rows_pick, cols_pick);
            steady_sender = ($urandom_range(0, 5) == 0);
            if (rows_now > 0 && cols_now > 0)
                fill_region($urandom_range(0, 7) != 0);
            if (phase == 1)
                hold_off_asks <= hold_off_asks + 1;
            searches = $urandom_range(20, 60);
            repeat (searches) begin
                if ($urandom_range(0, 99) < 15)
                    write_cell(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
                else
                    look_up(pick_key());
            end
            phase++;
        end

        drain_block();
        if (mismatches == 0) begin
            $display("sorted_matrix_binary_search_test: clean");
        end else begin
            $display("sorted_matrix_binary_search_test: errors");
        end
        $finish;
    end

endmodule

@@ sorted_matrix_binary_search.f @@
hw/rtl/smbs_pkg.sv
hw/rtl/smbs_ram.sv
hw/rtl/sorted_matrix_binary_search.sv
tb/sorted_matrix_binary_search_checker.sv
tb/sorted_matrix_binary_search_test.sv
